// ===== sv/i2cms_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package i2cms_pkg;

    // default width of the data byte counter
    localparam int CNT_BITS_DEF = 16;

    // configuration register indexes
    localparam logic [2:0] REG_DEVICE_ADDRESS     = 3'd0;
    localparam logic [2:0] REG_SUB_ADDRESS        = 3'd1;
    localparam logic [2:0] REG_SUB_ADDRESS_KIND   = 3'd2;
    localparam logic [2:0] REG_TRANSFER_LENGTH    = 3'd3;
    localparam logic [2:0] REG_TRANSFER_DIRECTION = 3'd4;

    // item kinds carried on tuser
    localparam logic ACT_BEGIN = 1'b0;
    localparam logic ACT_EVENT = 1'b1;

    // sub-address kinds
    localparam logic [1:0] KIND_TWO_BYTES = 2'd2;
    localparam logic [1:0] KIND_FOLDED    = 2'd3;

    // controller status codes, low three bits stripped
    localparam logic [7:0] STAT_MASK     = 8'hf8;
    localparam logic [7:0] ST_START      = 8'h08;
    localparam logic [7:0] ST_RSTART     = 8'h10;
    localparam logic [7:0] ST_SLAW_ACK   = 8'h18;
    localparam logic [7:0] ST_SLAW_NACK  = 8'h20;
    localparam logic [7:0] ST_DATA_ACK   = 8'h28;
    localparam logic [7:0] ST_DATA_NACK  = 8'h30;
    localparam logic [7:0] ST_ARB_LOST   = 8'h38;
    localparam logic [7:0] ST_SLAR_ACK   = 8'h40;
    localparam logic [7:0] ST_SLAR_NACK  = 8'h48;
    localparam logic [7:0] ST_RX_ACK     = 8'h50;
    localparam logic [7:0] ST_RX_NACK    = 8'h58;

    // control register masks
    localparam logic [6:0] CTL_NONE      = 7'h00;
    localparam logic [6:0] CTL_AA        = 7'h04;
    localparam logic [6:0] CTL_SI        = 7'h08;
    localparam logic [6:0] CTL_STO       = 7'h10;
    localparam logic [6:0] CTL_STA       = 7'h20;
    localparam logic [6:0] CTL_EN_STA    = 7'h60;
    localparam logic [6:0] CLR_SI_STA    = 7'h28;
    localparam logic [6:0] CLR_SI_STA_AA = 7'h2c;

    localparam logic [7:0] RD_CLR_MASK   = 8'hfe;

    typedef enum logic [1:0] {
        PH_DATA  = 2'd0,
        PH_READ  = 2'd1,
        PH_WRITE = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        OUT_RUNNING = 2'd0,
        OUT_DONE    = 2'd1,
        OUT_FAIL    = 2'd2
    } outcome_t;

    // one result item, last field in the lowest bits
    typedef struct packed {
        logic [4:0] pad;
        outcome_t   outcome;
        logic       write_taken;
        logic       rx_store;
        logic [7:0] rx_byte;
        logic [6:0] control_clear;
        logic [6:0] control_set;
        logic       tx_load;
        logic [7:0] tx_byte;
    } result_t;

endpackage

`default_nettype wire

// ===== sv/i2c_master_subaddress_sequencer.sv =====
// I2C master transfer sequencer with a device sub-address. Write the five
// configuration registers while idle, then send an item with tuser = 0 to
// begin a transfer: it latches the target address, sub-address and byte
// count and asks for a start condition (a zero length fails at once and
// leaves the state alone). Every later controller status value is sent as
// an item with tuser = 1; each item gives exactly one result item with the
// byte to load, the control bits to set and clear, any received byte and
// the outcome (0 running, 1 done, 2 failed). The block takes one item per
// clock cycle while results are read; a result shows in the cycle after its
// item is accepted and sits in the output register, which is refilled in the
// same cycle it is taken, so tready only drops while a result waits unread.
`timescale 1ns / 1ps
`default_nettype none

module i2c_master_subaddress_sequencer
    import i2cms_pkg::*;
#(
    parameter int COUNT_BITS = CNT_BITS_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // status_code [7:0], bus_byte [15:8], write_byte [23:16]
    input  wire logic [23:0] s_tdata,
    // action [0]
    input  wire logic [0:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // tx_byte [7:0], tx_load [8], control_set [15:9], control_clear [22:16],
    // rx_byte [30:23], rx_store [31], write_taken [32], outcome [34:33]
    output logic [39:0]      m_tdata
);

    // configuration registers
    logic [7:0]  device_address_reg;
    logic [15:0] sub_address_reg;
    logic [1:0]  sub_address_kind_reg;
    logic [15:0] transfer_length_reg;
    logic        transfer_direction_reg;

    // transfer state
    phase_t                phase_reg, phase_next;
    logic [1:0]            sub_left_reg, sub_left_next;
    logic [COUNT_BITS-1:0] bytes_left_reg, bytes_left_next;
    logic [7:0]            target_reg, target_next;
    logic [15:0]           sub_latch_reg, sub_latch_next;
    outcome_t              end_flag_reg, end_flag_next;

    // output stage
    logic    out_valid_reg;
    result_t result_reg, result_next;

    // unpacked item
    logic       accept;
    logic       action;
    logic [7:0] status;
    logic [7:0] bus_byte;
    logic [7:0] write_byte;

    // begin decode
    logic [31:0]           len_wide;
    logic [COUNT_BITS-1:0] len;
    logic                  len_zero;
    logic                  rd;
    logic [7:0]            fold_add;
    logic [COUNT_BITS-1:0] rx_left;

    assign s_tready   = !out_valid_reg || m_tready;
    assign accept     = s_tvalid && s_tready;
    assign action     = s_tuser[0];
    assign status     = s_tdata[7:0] & STAT_MASK;
    assign bus_byte   = s_tdata[15:8];
    assign write_byte = s_tdata[23:16];

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = result_reg;

    // length trimmed or widened to the counter
    assign len_wide = {16'd0, transfer_length_reg};
    assign len      = len_wide[COUNT_BITS-1:0];
    assign len_zero = (len == '0);
    assign rd       = transfer_direction_reg;
    // folded kind puts sub-address bits 10..8 into address bits 3..1
    assign fold_add = (sub_address_kind_reg == KIND_FOLDED)
                    ? {4'd0, sub_address_reg[10:8], 1'b0} : 8'd0;
    // receive count after one more byte, saturating at zero
    assign rx_left  = (bytes_left_reg != '0) ? bytes_left_reg - COUNT_BITS'(1)
                                             : bytes_left_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            device_address_reg     <= 8'd0;
            sub_address_reg        <= 16'd0;
            sub_address_kind_reg   <= 2'd1;
            transfer_length_reg    <= 16'd1;
            transfer_direction_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_DEVICE_ADDRESS:     device_address_reg     <= cfg_data[7:0];
                REG_SUB_ADDRESS:        sub_address_reg        <= cfg_data;
                REG_SUB_ADDRESS_KIND:   sub_address_kind_reg   <= cfg_data[1:0];
                REG_TRANSFER_LENGTH:    transfer_length_reg    <= cfg_data;
                REG_TRANSFER_DIRECTION: transfer_direction_reg <= cfg_data[0];
                default:                ;
            endcase
        end
    end

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (action == ACT_BEGIN)
        begin
            if (!len_zero)
                phase_next = rd ? PH_READ : PH_WRITE;
        end
        else if (status == ST_SLAW_ACK || status == ST_DATA_ACK)
        begin
            if (phase_reg != PH_DATA)
            begin
                // last sub-address byte of a write, or repeated start of a read
                if (sub_left_reg == 2'd1 && phase_reg == PH_WRITE)
                    phase_next = PH_DATA;
                else if (sub_left_reg == 2'd0 && phase_reg == PH_READ)
                    phase_next = PH_DATA;
            end
        end
    end

    // result and remaining state
    always_comb
    begin
        result_next     = '0;
        sub_left_next   = sub_left_reg;
        bytes_left_next = bytes_left_reg;
        target_next     = target_reg;
        sub_latch_next  = sub_latch_reg;
        end_flag_next   = end_flag_reg;

        if (action == ACT_BEGIN)
        begin
            if (len_zero)
            begin
                result_next.outcome = OUT_FAIL;
            end
            else
            begin
                sub_latch_next = sub_address_reg;
                if (sub_address_kind_reg == KIND_FOLDED && rd)
                    sub_latch_next = {8'd0, sub_address_reg[7:0]};
                sub_left_next   = (sub_address_kind_reg == KIND_TWO_BYTES) ? 2'd2 : 2'd1;
                target_next     = device_address_reg + fold_add + {7'd0, rd};
                bytes_left_next = len;
                end_flag_next   = OUT_RUNNING;
                result_next.control_clear = CLR_SI_STA_AA;
                result_next.control_set   = CTL_EN_STA;
                result_next.outcome       = OUT_RUNNING;
            end
        end
        else
        begin
            unique case (status)
                ST_START:
                begin
                    // first address is always the write address
                    result_next.tx_byte = (phase_reg == PH_READ)
                                        ? (target_reg & RD_CLR_MASK) : target_reg;
                    result_next.tx_load       = 1'b1;
                    result_next.control_clear = CLR_SI_STA;
                end
                ST_RSTART:
                begin
                    result_next.tx_byte       = target_reg;
                    result_next.tx_load       = 1'b1;
                    result_next.control_clear = CLR_SI_STA;
                end
                ST_SLAW_ACK, ST_DATA_ACK:
                begin
                    if (phase_reg == PH_DATA)
                    begin
                        result_next.control_clear = CLR_SI_STA;
                        if (bytes_left_reg != '0)
                        begin
                            result_next.tx_byte     = write_byte;
                            result_next.tx_load     = 1'b1;
                            result_next.write_taken = 1'b1;
                            bytes_left_next         = bytes_left_reg - COUNT_BITS'(1);
                        end
                        else
                        begin
                            result_next.control_set = CTL_STO;
                            end_flag_next           = OUT_DONE;
                        end
                    end
                    else if (sub_left_reg == 2'd2)
                    begin
                        result_next.tx_byte       = sub_latch_reg[15:8];
                        result_next.tx_load       = 1'b1;
                        result_next.control_clear = CLR_SI_STA;
                        sub_left_next             = 2'd1;
                    end
                    else if (sub_left_reg == 2'd1)
                    begin
                        result_next.tx_byte       = sub_latch_reg[7:0];
                        result_next.tx_load       = 1'b1;
                        result_next.control_clear = CLR_SI_STA;
                        sub_left_next             = 2'd0;
                    end
                    else if (sub_left_reg == 2'd0 && phase_reg == PH_READ)
                    begin
                        // repeated start for the read address
                        result_next.control_clear = CTL_SI;
                        result_next.control_set   = CTL_STA;
                    end
                end
                ST_SLAR_ACK:
                begin
                    if (bytes_left_reg <= COUNT_BITS'(1))
                    begin
                        result_next.control_clear = CLR_SI_STA_AA;
                    end
                    else
                    begin
                        result_next.control_set   = CTL_AA;
                        result_next.control_clear = CLR_SI_STA;
                    end
                end
                ST_SLAW_NACK, ST_DATA_NACK, ST_ARB_LOST, ST_SLAR_NACK:
                begin
                    result_next.control_clear = CLR_SI_STA;
                    end_flag_next             = OUT_FAIL;
                end
                ST_RX_ACK:
                begin
                    result_next.rx_byte  = bus_byte;
                    result_next.rx_store = 1'b1;
                    bytes_left_next      = rx_left;
                    // nack the last byte
                    if (rx_left == COUNT_BITS'(1))
                    begin
                        result_next.control_clear = CLR_SI_STA_AA;
                    end
                    else
                    begin
                        result_next.control_set   = CTL_AA;
                        result_next.control_clear = CLR_SI_STA;
                    end
                end
                ST_RX_NACK:
                begin
                    result_next.rx_byte       = bus_byte;
                    result_next.rx_store      = 1'b1;
                    result_next.control_set   = CTL_STO;
                    result_next.control_clear = CLR_SI_STA;
                    end_flag_next             = OUT_DONE;
                end
                default:
                    ;
            endcase
            result_next.outcome = end_flag_next;
        end
    end

    // state and output registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_DATA;
            sub_left_reg   <= 2'd0;
            bytes_left_reg <= '0;
            target_reg     <= 8'd0;
            sub_latch_reg  <= 16'd0;
            end_flag_reg   <= OUT_RUNNING;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg      <= phase_next;
                sub_left_reg   <= sub_left_next;
                bytes_left_reg <= bytes_left_next;
                target_reg     <= target_next;
                sub_latch_reg  <= sub_latch_next;
                end_flag_reg   <= end_flag_next;
                out_valid_reg  <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
            result_reg <= result_next;
    end

endmodule

`default_nettype wire

// ===== sv/i2cms_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module i2cms_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [0:0]  s_tuser,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [39:0] m_tdata
);

    // an accepted item always leaves a result behind
    a_item_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> m_tvalid)
        else $error("accepted item produced no result");

    // an empty output register never holds off the input
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // a stalled result holds
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

    // payload bytes are clear unless flagged
    a_bytes_flagged: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tdata[8] || m_tdata[7:0] == 8'd0)
                   && (m_tdata[31] || m_tdata[30:23] == 8'd0)))
        else $error("unflagged byte not zero");

    // a begin item reports running or failed, never done
    a_begin_outcome: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && !s_tuser[0]) |=> (m_tdata[34:33] != 2'd1))
        else $error("begin item reported done");

endmodule

bind i2c_master_subaddress_sequencer i2cms_checker u_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
